### hw/rtl/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the chunked body decoder: byte kind codes,
// the per-byte result flags and the default length width.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   // Default width of the chunk length accumulator and byte counter
   localparam int LENGTH_BITS_DEFAULT = 63;

   // Classification of each byte of the body
   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_FRAMING = 3'd1,
      KIND_TRAILER = 3'd2,
      KIND_AFTER   = 3'd3,
      KIND_ERROR   = 3'd4
   } byte_kind_type;

   // Flags produced for one request, parser to output stage
   typedef struct packed {
      byte_kind_type kind;
      logic          chunk_last;
      logic          length_valid;
      logic          finished;
      logic          error;
   } rsp_flags_type;

endpackage

### hw/rtl/hcbd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_parser
// Chunk framing state machine. Holds the parse phase, length accumulator,
// remaining payload count and trailer colon flag, and classifies one byte
// per enabled cycle.
// ----------------------------------------------------------------------------
module hcbd_parser #(
   parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  logic                      bypass,
   input  logic [7:0]                data_byte,
   output hcbd_pkg::rsp_flags_type   flags,
   output logic [LENGTH_BITS-1:0]    chunk_length
);
   import hcbd_pkg::*;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam int         HEX_BITS   = 4;

   // Accumulator values below this limit may still take another hex digit
   localparam logic [LENGTH_BITS-1:0] LEN_LIMIT =
      {{HEX_BITS{1'b0}}, {(LENGTH_BITS-HEX_BITS){1'b1}}};

   typedef enum logic [2:0] {
      PH_OPT_CR  = 3'd0,
      PH_OPT_LF  = 3'd1,
      PH_HEADER  = 3'd2,
      PH_EXT     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_TRAILER = 3'd5,
      PH_DONE    = 3'd6,
      PH_ERROR   = 3'd7
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] accum_ff, accum_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [LENGTH_BITS-1:0] left_dec;
   logic                   colon_ff, colon_in;
   logic                   hdr_byte, end_hdr;
   logic                   hex_ok;
   logic [HEX_BITS-1:0]    hex_val;
   byte_kind_type          kind;
   logic                   last;

   // Hex digit decode: 0-9, a-f, A-F
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = '0;
      if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
         hex_val = HEX_BITS'(data_byte - 8'h30);
      end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
         hex_val = HEX_BITS'(data_byte - 8'h57);
      end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
         hex_val = HEX_BITS'(data_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // Saturating decrement of the payload counter
   assign left_dec = (left_ff != '0) ? (left_ff - LENGTH_BITS'(1)) : '0;

   // Next state and classification
   always_comb begin
      phase_in     = phase_ff;
      accum_in     = accum_ff;
      left_in      = left_ff;
      colon_in     = colon_ff;
      kind         = KIND_PAYLOAD;
      last         = 1'b0;
      hdr_byte     = 1'b0;
      end_hdr      = 1'b0;
      chunk_length = '0;

      if (!bypass) begin
         unique case (phase_ff)
            PH_OPT_CR: begin
               if (data_byte == CHAR_CR) begin
                  kind     = KIND_FRAMING;
                  phase_in = PH_OPT_LF;
               end else if (data_byte == CHAR_LF) begin
                  kind     = KIND_FRAMING;
                  phase_in = PH_HEADER;
               end else begin
                  hdr_byte = 1'b1;
               end
            end
            PH_OPT_LF: begin
               if (data_byte == CHAR_LF) begin
                  kind     = KIND_FRAMING;
                  phase_in = PH_HEADER;
               end else begin
                  hdr_byte = 1'b1;
               end
            end
            PH_HEADER: begin
               hdr_byte = 1'b1;
            end
            PH_EXT: begin
               kind = KIND_FRAMING;
               if (data_byte == CHAR_LF) end_hdr = 1'b1;
            end
            PH_PAYLOAD: begin
               kind    = KIND_PAYLOAD;
               left_in = left_dec;
               if (left_dec == '0) begin
                  last     = 1'b1;
                  phase_in = PH_OPT_CR;
               end
            end
            PH_TRAILER: begin
               kind = KIND_TRAILER;
               if (data_byte == CHAR_COLON) begin
                  colon_in = 1'b1;
               end else if (data_byte == CHAR_LF) begin
                  if (colon_ff) colon_in = 1'b0;
                  else          phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
               kind = KIND_AFTER;
            end
            PH_ERROR: begin
               kind = KIND_ERROR;
            end
         endcase

         // Header line byte: hex digits, CR ignored, LF ends, ';' opens extension
         if (hdr_byte) begin
            phase_in = PH_HEADER;
            kind     = KIND_FRAMING;
            if (data_byte == CHAR_CR) begin
               kind = KIND_FRAMING;
            end else if (data_byte == CHAR_LF) begin
               end_hdr = 1'b1;
            end else if (data_byte == CHAR_SEMI) begin
               phase_in = PH_EXT;
            end else if (!hex_ok || accum_ff >= LEN_LIMIT) begin
               phase_in = PH_ERROR;
               kind     = KIND_ERROR;
            end else begin
               accum_in = {accum_ff[LENGTH_BITS-HEX_BITS-1:0], hex_val};
            end
         end

         // End of header line: publish length, go to payload or trailer
         if (end_hdr) begin
            chunk_length = accum_ff;
            accum_in     = '0;
            if (accum_ff != '0) begin
               left_in  = accum_ff;
               phase_in = PH_PAYLOAD;
            end else begin
               colon_in = 1'b0;
               phase_in = PH_TRAILER;
            end
         end
      end

      flags.kind         = kind;
      flags.chunk_last   = last;
      flags.length_valid = end_hdr;
      flags.finished     = (phase_in == PH_DONE);
      flags.error        = (phase_in == PH_ERROR);
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPT_CR;
         accum_ff <= '0;
         left_ff  <= '0;
         colon_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
         colon_ff <= colon_in;
      end
   end

endmodule

### hw/rtl/http_chunked_body_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Classifies each byte of a chunked HTTP body as payload, framing, trailer,
// after-end or error, one byte per cycle while the response side does not stall.
// ----------------------------------------------------------------------------
// One request (one body byte) is taken every cycle while req_stall is low
// and gives exactly one response. The byte lands in an input register, the
// parser classifies it and updates its phase, length accumulator and payload
// counter, and the result sits in the output register. One byte per cycle,
// without response stalls, is set by the parser state update. Backpressure on
// the response side stalls the input register, and req_stall rises only when
// both registers are full. The user must write the bypass bit through
// csr_wr_en/csr_wr_data only while the block is idle; nothing enforces it.
module http_chunked_body_decoder_top #(
   parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_byte_out,
   output logic [2:0]             rsp_byte_kind,
   output logic                   rsp_chunk_last,
   output logic                   rsp_length_valid,
   output logic [LENGTH_BITS-1:0] rsp_chunk_length,
   output logic                   rsp_finished,
   output logic                   rsp_error
);
   import hcbd_pkg::*;

   logic                   bypass_ff;
   logic                   req_valid_ff;
   logic [7:0]             req_byte_ff;
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_byte_ff;
   rsp_flags_type          rsp_flags_ff;
   logic [LENGTH_BITS-1:0] rsp_length_ff;
   logic                   out_load;
   logic                   in_load;
   rsp_flags_type          flags;
   logic [LENGTH_BITS-1:0] chunk_length;

   // Pipeline advance
   assign out_load  = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign in_load   = !req_valid_ff || out_load;
   assign req_stall = !in_load;

   // Bypass register
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (csr_wr_en) begin
         bypass_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (in_load) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) req_byte_ff <= req_data_byte;
   end

   hcbd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (out_load),
      .bypass       (bypass_ff),
      .data_byte    (req_byte_ff),
      .flags        (flags),
      .chunk_length (chunk_length)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_byte_ff   <= req_byte_ff;
         rsp_flags_ff  <= flags;
         rsp_length_ff <= chunk_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = rsp_byte_ff;
   assign rsp_byte_kind    = rsp_flags_ff.kind;
   assign rsp_chunk_last   = rsp_flags_ff.chunk_last;
   assign rsp_length_valid = rsp_flags_ff.length_valid;
   assign rsp_chunk_length = rsp_length_ff;
   assign rsp_finished     = rsp_flags_ff.finished;
   assign rsp_error        = rsp_flags_ff.error;

   // Checks
   a_len_is_framing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_valid |-> rsp_byte_kind == KIND_FRAMING)
      else $error("length_valid on a non-framing byte");

   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chunk_last |-> rsp_byte_kind == KIND_PAYLOAD)
      else $error("chunk_last on a non-payload byte");

   a_done_xor_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_finished && rsp_error))
      else $error("finished and error both set");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled with room in the pipeline");

endmodule
